>>> design/fcr_pkg.sv
// Package for the framed command receiver: widths, codes and the frame view
// passed from the framer to the executor. No dependencies.
package fcr_pkg;

	localparam int CAPTURE_DEPTH = 16;
	localparam int CAP_IDX_W     = $clog2(CAPTURE_DEPTH);
	localparam int CFG_DATA_W    = 16;

	localparam logic [7:0]  SYNC_CODE_RST = 8'd254;
	localparam logic [15:0] PULSES_RST    = 16'd1900;
	localparam logic [14:0] SPEED_SCALE   = 15'd100;

	typedef enum logic [0:0] {
		REG_SYNC_CODE = 1'b0,
		REG_PULSES    = 1'b1
	} cfg_reg_t;

	localparam logic [7:0] TYPE_CONTROL = 8'd1;
	localparam logic [7:0] TYPE_PARAM   = 8'd2;
	localparam logic [7:0] TYPE_MOTOR   = 8'd3;

	localparam logic [7:0] CMD_RUN  = 8'h72;
	localparam logic [7:0] CMD_STOP = 8'h73;
	localparam logic [7:0] CMD_TX   = 8'h74;

	localparam logic [1:0] TX_SEL_LAST = 2'd2;

	typedef enum logic [1:0] {
		KIND_CONTROL = 2'd0,
		KIND_PARAM   = 2'd1,
		KIND_MOTOR   = 2'd2,
		KIND_OTHER   = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		ST_OK       = 1'b0,
		ST_MISMATCH = 1'b1
	} status_t;

	// Captured bytes as seen at frame completion, the final byte included.
	typedef struct packed {
		logic       done;
		logic [7:0] final_byte;
		logic [7:0] sum;
		logic [7:0] typ;
		logic [7:0] d2;
		logic [7:0] d3;
		logic [7:0] d4;
		logic [7:0] d5;
		logic [7:0] d6;
		logic [7:0] d7;
		logic [7:0] d14;
		logic [7:0] d15;
	} frame_t;

endpackage

>>> design/fcr_ifs.sv
// Handshake interfaces for the received byte channel and the result channel.
// No dependencies.
interface fcr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcr_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [1:0]  frame_kind;
	logic        run_enabled;
	logic        tx_enabled;
	logic [1:0]  tx_select;
	logic [23:0] distance_pulses;
	logic [14:0] speed_limit;
	logic [7:0]  pass_value;
	logic [23:0] pid_gains;
	logic [15:0] steer_gains;
	logic [7:0]  motor_index;
	logic [7:0]  motor_dir;

	modport source (output valid, output status, output frame_kind, output run_enabled,
		output tx_enabled, output tx_select, output distance_pulses, output speed_limit,
		output pass_value, output pid_gains, output steer_gains, output motor_index,
		output motor_dir, input ready);
	modport sink (input valid, input status, input frame_kind, input run_enabled,
		input tx_enabled, input tx_select, input distance_pulses, input speed_limit,
		input pass_value, input pid_gains, input steer_gains, input motor_index,
		input motor_dir, output ready);
endinterface

>>> design/framed_command_receiver.sv
// Framed command receiver: one received byte per transaction, one result per frame.
// A frame's final byte passes through the input-stage register and then its result is registered in the result stage.
// Throughput: one byte per cycle, limited only by the result channel being held.
// Reset clears all frame state, the capture store and the held registers, and
// loads sync_code 254 and pulses_per_metre 1900. Depends on fcr_pkg, fcr_ifs, fcr_framer and fcr_exec.
module framed_command_receiver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  fcr_pkg::cfg_reg_t                  cfg_index,
	input  logic [fcr_pkg::CFG_DATA_W-1:0]     cfg_data,
	fcr_rx_if.sink                             rx,
	fcr_res_if.source                          res
);
	import fcr_pkg::*;

	logic [7:0]  sync_code_q;
	logic [15:0] pulses_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        step;
	frame_t      frame;

	assign advance  = !res.valid || res.ready;
	assign rx.ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_code_q <= SYNC_CODE_RST;
			pulses_q    <= PULSES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_CODE: sync_code_q <= cfg_data[7:0];
				REG_PULSES:    pulses_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	fcr_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.sync_code (sync_code_q),
		.frame     (frame)
	);

	fcr_exec u_exec (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.frame            (frame),
		.pulses_per_metre (pulses_q),
		.res              (res)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		res.tx_select != 2'd3)
		else $error("Transmit select left its 0 to 2 range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(valid_s1))
		else $error("Result appeared without a byte in the input stage.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status |->
			(res.frame_kind == KIND_PARAM) || (res.frame_kind == KIND_MOTOR))
		else $error("Checksum mismatch reported for a frame type without a check.");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.valid && !res.ready |-> !rx.ready)
		else $error("Byte accepted while the input stage is blocked.");

endmodule

>>> design/fcr_framer.sv
// Frame tracker: sync detection, length, position, running sum and byte capture.
// Depends on fcr_pkg.
module fcr_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_s1,
	input  logic [7:0]        sync_code,
	output fcr_pkg::frame_t   frame
);
	import fcr_pkg::*;

	logic       in_frame_q;
	logic [7:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] sum_q;
	logic [7:0] cap_q [CAPTURE_DEPTH];

	logic is_sync;
	logic take_len;
	logic take_body;
	logic take_last;
	logic do_store;

	assign is_sync   = (byte_s1 == sync_code);
	assign take_len  = in_frame_q && !is_sync && (pos_q == 8'd0);
	assign take_body = in_frame_q && !is_sync && (pos_q != 8'd0) && (pos_q < len_q);
	assign take_last = in_frame_q && !is_sync && (pos_q != 8'd0) && (pos_q == len_q);
	assign do_store  = (take_body || take_last) && (int'(pos_q) < CAPTURE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			for (int i = 0; i < CAPTURE_DEPTH; i++) begin
				cap_q[i] <= '0;
			end
		end else if (step) begin
			if (is_sync) begin
				in_frame_q <= 1'b1;
				pos_q      <= '0;
				sum_q      <= '0;
				for (int i = 0; i < CAPTURE_DEPTH; i++) begin
					cap_q[i] <= '0;
				end
			end else begin
				if (take_len) begin
					len_q <= byte_s1;
					pos_q <= 8'd1;
				end
				if (take_body) begin
					pos_q <= pos_q + 8'd1;
					if (pos_q >= 8'd2) begin
						sum_q <= sum_q + byte_s1;
					end
				end
				if (take_last) begin
					in_frame_q <= 1'b0;
				end
				if (do_store) begin
					cap_q[pos_q[CAP_IDX_W-1:0]] <= byte_s1;
				end
			end
		end
	end

	function automatic logic [7:0] view(input int idx, input logic [7:0] p,
		input logic [7:0] b, input logic [7:0] stored);
		return (p == 8'(idx)) ? b : stored;
	endfunction

	always_comb begin
		frame.done       = step && take_last;
		frame.final_byte = byte_s1;
		frame.sum        = sum_q;
		frame.typ        = view(1, pos_q, byte_s1, cap_q[1]);
		frame.d2         = view(2, pos_q, byte_s1, cap_q[2]);
		frame.d3         = view(3, pos_q, byte_s1, cap_q[3]);
		frame.d4         = view(4, pos_q, byte_s1, cap_q[4]);
		frame.d5         = view(5, pos_q, byte_s1, cap_q[5]);
		frame.d6         = view(6, pos_q, byte_s1, cap_q[6]);
		frame.d7         = view(7, pos_q, byte_s1, cap_q[7]);
		frame.d14        = view(14, pos_q, byte_s1, cap_q[14]);
		frame.d15        = view(15, pos_q, byte_s1, cap_q[15]);
	end

endmodule

>>> design/fcr_exec.sv
// Frame decoder with the held command registers and the result register.
// Depends on fcr_pkg and fcr_res_if.
module fcr_exec (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  fcr_pkg::frame_t frame,
	input  logic [15:0]     pulses_per_metre,
	fcr_res_if.source       res
);
	import fcr_pkg::*;

	logic        valid_q;
	status_t     status_q;
	kind_t       kind_q;
	logic        run_q;
	logic        tx_q;
	logic [1:0]  tx_sel_q;
	logic [23:0] dist_q;
	logic [14:0] speed_q;
	logic [7:0]  pass_q;
	logic [23:0] gain_q;
	logic [15:0] steer_q;
	logic [7:0]  motor_idx_q;
	logic [7:0]  motor_dir_q;

	kind_t       kind_d;
	logic        sum_ok;
	logic        motor_ok;
	logic [23:0] dist_d;
	logic [14:0] speed_d;

	always_comb begin
		case (frame.typ)
			TYPE_CONTROL: kind_d = KIND_CONTROL;
			TYPE_PARAM:   kind_d = KIND_PARAM;
			TYPE_MOTOR:   kind_d = KIND_MOTOR;
			default:      kind_d = KIND_OTHER;
		endcase
	end

	assign sum_ok   = (frame.sum == frame.final_byte);
	assign motor_ok = (frame.d4 == 8'(frame.d2 + frame.d3));
	assign dist_d   = {16'd0, frame.d2} * {8'd0, pulses_per_metre};
	assign speed_d  = {7'd0, frame.d3} * SPEED_SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			status_q    <= ST_OK;
			kind_q      <= KIND_CONTROL;
			run_q       <= 1'b0;
			tx_q        <= 1'b0;
			tx_sel_q    <= '0;
			dist_q      <= '0;
			speed_q     <= '0;
			pass_q      <= '0;
			gain_q      <= '0;
			steer_q     <= '0;
			motor_idx_q <= '0;
			motor_dir_q <= '0;
		end else if (advance) begin
			valid_q <= frame.done;
			if (frame.done) begin
				kind_q   <= kind_d;
				status_q <= ST_OK;
				case (kind_d)
					KIND_CONTROL: begin
						if (frame.d2 == CMD_RUN) begin
							run_q <= 1'b1;
						end else if (frame.d2 == CMD_STOP) begin
							run_q <= 1'b0;
						end else if (frame.d2 == CMD_TX) begin
							tx_q     <= 1'b1;
							tx_sel_q <= (tx_sel_q >= TX_SEL_LAST) ? 2'd0 : tx_sel_q + 2'd1;
						end
					end
					KIND_PARAM: begin
						if (sum_ok) begin
							dist_q  <= dist_d;
							speed_q <= speed_d;
							pass_q  <= frame.d4;
							gain_q  <= {frame.d5, frame.d6, frame.d7};
							steer_q <= {frame.d14, frame.d15};
						end else begin
							status_q <= ST_MISMATCH;
						end
					end
					KIND_MOTOR: begin
						if (motor_ok) begin
							motor_idx_q <= frame.d2;
							motor_dir_q <= frame.d3;
						end else begin
							status_q <= ST_MISMATCH;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign res.valid           = valid_q;
	assign res.status          = status_q;
	assign res.frame_kind      = kind_q;
	assign res.run_enabled     = run_q;
	assign res.tx_enabled      = tx_q;
	assign res.tx_select       = tx_sel_q;
	assign res.distance_pulses = dist_q;
	assign res.speed_limit     = speed_q;
	assign res.pass_value      = pass_q;
	assign res.pid_gains       = gain_q;
	assign res.steer_gains     = steer_q;
	assign res.motor_index     = motor_idx_q;
	assign res.motor_dir       = motor_dir_q;

endmodule

>>> verif/testbench.sv
// Testbench for framed_command_receiver: drives received bytes, predicts one result per
// completed frame and checks every field of each result transaction in order.
// Depends on fcr_pkg, fcr_ifs and the framed_command_receiver RTL.
module testbench;
	import fcr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] octet_q_t[$];

	typedef struct {
		status_t     status;
		kind_t       kind;
		logic        run;
		logic        tx;
		logic [1:0]  tx_sel;
		logic [23:0] dist_pulses;
		logic [14:0] speed;
		logic [7:0]  pass;
		logic [23:0] gains;
		logic [15:0] steer;
		logic [7:0]  motor_idx;
		logic [7:0]  motor_dir;
	} frame_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fcr_rx_if  rx_bus ();
	fcr_res_if res_bus ();

	framed_command_receiver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_bus),
		.res       (res_bus)
	);

	// Predicted receiver state.
	logic [7:0]  cfg_sync;
	logic [15:0] pulse_scale;
	logic        framing;
	logic [7:0]  pos;
	logic [7:0]  flen;
	logic [7:0]  csum;
	logic [7:0]  cap_mem [CAPTURE_DEPTH];
	logic        run_q;
	logic        tx_q;
	logic [1:0]  tx_sel_q;
	logic [23:0] dist_q;
	logic [14:0] speed_q;
	logic [7:0]  pass_q;
	logic [23:0] gains_q;
	logic [15:0] steer_q;
	logic [7:0]  motor_idx_q;
	logic [7:0]  motor_dir_q;

	frame_result_t pending_results[$];
	int            errors;
	bit            send_idle;
	bit            recv_idle;
	int            stall_left;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SYNC_CODE;
		cfg_data = '0;
		rx_bus.valid = 1'b0;
		rx_bus.rx_byte = 8'h00;
		res_bus.ready = 1'b0;
		errors = 0;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		stall_left = 0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_bus.ready <= 1'b0;
		end else if (recv_idle && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 19) - 1;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d status %0d",
					$time, res_bus.frame_kind, res_bus.status);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 24'(want.status), 24'(res_bus.status));
				check_field("frame_kind", 24'(want.kind), 24'(res_bus.frame_kind));
				check_field("run_enabled", 24'(want.run), 24'(res_bus.run_enabled));
				check_field("tx_enabled", 24'(want.tx), 24'(res_bus.tx_enabled));
				check_field("tx_select", 24'(want.tx_sel), 24'(res_bus.tx_select));
				check_field("distance_pulses", want.dist_pulses, res_bus.distance_pulses);
				check_field("speed_limit", 24'(want.speed), 24'(res_bus.speed_limit));
				check_field("pass_value", 24'(want.pass), 24'(res_bus.pass_value));
				check_field("pid_gains", want.gains, res_bus.pid_gains);
				check_field("steer_gains", 24'(want.steer), 24'(res_bus.steer_gains));
				check_field("motor_index", 24'(want.motor_idx), 24'(res_bus.motor_index));
				check_field("motor_dir", 24'(want.motor_dir), 24'(res_bus.motor_dir));
			end
		end
	end

	task automatic clear_receiver_state();
		cfg_sync = SYNC_CODE_RST;
		pulse_scale = PULSES_RST;
		framing = 1'b0;
		pos = '0;
		flen = '0;
		csum = '0;
		foreach (cap_mem[i]) cap_mem[i] = '0;
		run_q = 1'b0;
		tx_q = 1'b0;
		tx_sel_q = '0;
		dist_q = '0;
		speed_q = '0;
		pass_q = '0;
		gains_q = '0;
		steer_q = '0;
		motor_idx_q = '0;
		motor_dir_q = '0;
	endtask

	task automatic predict_byte(input logic [7:0] b);
		frame_result_t r;
		if (b == cfg_sync) begin
			framing = 1'b1;
			pos = '0;
			csum = '0;
			foreach (cap_mem[i]) cap_mem[i] = '0;
			return;
		end
		if (!framing) return;
		if (pos == 0) begin
			flen = b;
			pos = 8'd1;
			return;
		end
		if (pos < flen) begin
			if (pos < CAPTURE_DEPTH) cap_mem[pos] = b;
			if (pos >= 2) csum = csum + b;
			pos = pos + 8'd1;
			return;
		end
		if (pos != flen) return;
		if (flen < CAPTURE_DEPTH) cap_mem[flen] = b;
		framing = 1'b0;
		r.status = ST_OK;
		case (cap_mem[1])
			TYPE_CONTROL: begin
				r.kind = KIND_CONTROL;
				if (cap_mem[2] == CMD_RUN) begin
					run_q = 1'b1;
				end else if (cap_mem[2] == CMD_STOP) begin
					run_q = 1'b0;
				end else if (cap_mem[2] == CMD_TX) begin
					tx_q = 1'b1;
					tx_sel_q = (tx_sel_q >= TX_SEL_LAST) ? 2'd0 : tx_sel_q + 2'd1;
				end
			end
			TYPE_PARAM: begin
				r.kind = KIND_PARAM;
				if (csum == b) begin
					dist_q = {16'd0, cap_mem[2]} * {8'd0, pulse_scale};
					speed_q = {7'd0, cap_mem[3]} * SPEED_SCALE;
					pass_q = cap_mem[4];
					gains_q = {cap_mem[5], cap_mem[6], cap_mem[7]};
					steer_q = {cap_mem[14], cap_mem[15]};
				end else begin
					r.status = ST_MISMATCH;
				end
			end
			TYPE_MOTOR: begin
				r.kind = KIND_MOTOR;
				if (cap_mem[4] == 8'(cap_mem[2] + cap_mem[3])) begin
					motor_idx_q = cap_mem[2];
					motor_dir_q = cap_mem[3];
				end else begin
					r.status = ST_MISMATCH;
				end
			end
			default: r.kind = KIND_OTHER;
		endcase
		r.run = run_q;
		r.tx = tx_q;
		r.tx_sel = tx_sel_q;
		r.dist_pulses = dist_q;
		r.speed = speed_q;
		r.pass = pass_q;
		r.gains = gains_q;
		r.steer = steer_q;
		r.motor_idx = motor_idx_q;
		r.motor_dir = motor_dir_q;
		pending_results.push_back(r);
	endtask

	// Called and returns at a falling edge; leaves valid high for the next byte.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (send_idle && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			rx_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_bus.valid <= 1'b1;
		rx_bus.rx_byte <= b;
		do @(posedge clk); while (rx_bus.ready !== 1'b1);
		predict_byte(b);
		@(negedge clk);
	endtask

	task automatic send_body(input octet_q_t body);
		send_byte(cfg_sync);
		send_byte(8'(body.size()));
		foreach (body[i]) send_byte(body[i]);
	endtask

	task automatic wait_drained();
		rx_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SYNC_CODE) cfg_sync = value[7:0];
		else pulse_scale = value;
	endtask

	function automatic logic [7:0] clean(input logic [7:0] b);
		return (b == cfg_sync) ? b ^ 8'h01 : b;
	endfunction

	function automatic logic [7:0] octet_sum(input octet_q_t body, input int from, input int upto);
		logic [7:0] s;
		s = '0;
		for (int i = from; i <= upto; i++) s = s + body[i];
		return s;
	endfunction

	// Index i of a body is frame position i + 1.
	function automatic octet_q_t with_sum(input octet_q_t body);
		octet_q_t q;
		q = body;
		q[q.size() - 1] = octet_sum(q, 1, q.size() - 2);
		return q;
	endfunction

	function automatic octet_q_t param_body(input int len, input bit good);
		octet_q_t q;
		logic [7:0] s, w;
		q.push_back(TYPE_PARAM);
		for (int i = 2; i < len; i++) q.push_back(clean(8'($urandom)));
		s = octet_sum(q, 1, q.size() - 1);
		if (good) begin
			while (s == cfg_sync) begin
				q[1] = clean(q[1] + 8'd1);
				s = octet_sum(q, 1, q.size() - 1);
			end
			q.push_back(s);
		end else begin
			do w = 8'($urandom); while (w == s || w == cfg_sync);
			q.push_back(w);
		end
		return q;
	endfunction

	function automatic octet_q_t motor_body(input int len, input bit good);
		octet_q_t q;
		logic [7:0] chk, w;
		q = {TYPE_MOTOR, clean(8'($urandom)), clean(8'($urandom))};
		chk = q[1] + q[2];
		if (good) begin
			while (chk == cfg_sync) begin
				q[2] = clean(q[2] + 8'd1);
				chk = q[1] + q[2];
			end
			q.push_back(chk);
		end else begin
			do w = 8'($urandom); while (w == chk || w == cfg_sync);
			q.push_back(w);
		end
		for (int i = 5; i <= len; i++) q.push_back(clean(8'($urandom)));
		return q;
	endfunction

	function automatic octet_q_t control_body(input int len);
		octet_q_t q;
		q.push_back(TYPE_CONTROL);
		if (len >= 2) begin
			case ($urandom_range(0, 3))
				0: q.push_back(CMD_RUN);
				1: q.push_back(CMD_STOP);
				2: q.push_back(CMD_TX);
				default: q.push_back(clean(8'($urandom)));
			endcase
		end
		for (int i = 3; i <= len; i++) q.push_back(clean(8'($urandom)));
		return q;
	endfunction

	function automatic octet_q_t other_body(input int len);
		octet_q_t q;
		logic [7:0] t;
		do t = clean(8'($urandom)); while (t == TYPE_CONTROL || t == TYPE_PARAM || t == TYPE_MOTOR);
		q.push_back(t);
		for (int i = 2; i <= len; i++) q.push_back(clean(8'($urandom)));
		return q;
	endfunction

	task automatic test_control_frames();
		send_body({TYPE_CONTROL, CMD_RUN});
		send_body({TYPE_CONTROL, CMD_TX});
		send_body({TYPE_CONTROL, CMD_TX, 8'h00});
		send_body({TYPE_CONTROL, CMD_TX});
		send_body({TYPE_CONTROL, CMD_TX});
		send_body({TYPE_CONTROL, CMD_STOP});
		send_body({TYPE_CONTROL, 8'h00});
		send_body({TYPE_CONTROL});
	endtask

	task automatic test_param_frames();
		octet_q_t q;
		q = {TYPE_PARAM};
		repeat (14) q.push_back(8'hFF);
		q.push_back(8'h00);
		send_body(with_sum(q));
		send_body({TYPE_PARAM, 8'h00, 8'h00, 8'h00, 8'h00});
		send_body({TYPE_PARAM, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00});
		send_body({TYPE_PARAM, 8'h00});
		send_body({TYPE_PARAM});
	endtask

	task automatic test_motor_frames();
		send_body({TYPE_MOTOR, 8'hFF, 8'h01, 8'h00});
		send_body({TYPE_MOTOR, 8'h05, 8'h06, 8'h0C});
		send_body({TYPE_MOTOR, 8'h09, 8'h80, 8'h89, 8'h55});
		send_body({TYPE_MOTOR});
	endtask

	task automatic test_framing_corners();
		octet_q_t q;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CMD_RUN);
		send_byte(cfg_sync);
		send_byte(8'd5);
		send_byte(TYPE_CONTROL);
		send_body({TYPE_CONTROL, CMD_RUN});
		send_byte(cfg_sync);
		send_byte(8'd0);
		send_byte(TYPE_CONTROL);
		send_byte(CMD_STOP);
		send_body({8'h00});
		send_body({8'hFF, 8'h12});
		q = {TYPE_PARAM};
		for (int i = 2; i <= 20; i++) q.push_back(8'(i * 11));
		send_body(with_sum(q));
		send_byte(cfg_sync);
		send_byte(cfg_sync);
		send_body({TYPE_MOTOR, 8'h10, 8'h20, 8'h30});
	endtask

	task automatic test_random_traffic(input int n_bytes);
		octet_q_t q;
		int count, pick, len;
		bit paused;
		count = 0;
		paused = 1'b0;
		while (count < n_bytes) begin
			if (!paused && count >= n_bytes / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			q.delete();
			if (pick < 20) begin
				q = control_body($urandom_range(0, 5) == 0 ? 1 : $urandom_range(2, 5));
			end else if (pick < 50) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 60) : $urandom_range(3, 16);
				if (pick == 49 && $urandom_range(0, 3) == 0)
					len = (cfg_sync == 8'd255) ? 254 : $urandom_range(200, 255);
				q = param_body(len, $urandom_range(0, 6) != 0);
			end else if (pick < 70) begin
				q = motor_body($urandom_range(4, 7), $urandom_range(0, 6) != 0);
			end else if (pick < 78) begin
				q = other_body($urandom_range(1, 6));
			end else if (pick < 86) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else if (pick < 94) begin
				send_byte(cfg_sync);
				len = $urandom_range(3, 10);
				send_byte(clean(8'(len)));
				repeat ($urandom_range(0, len - 1)) send_byte(clean(8'($urandom)));
			end else if (cfg_sync != 8'd0) begin
				send_byte(cfg_sync);
				send_byte(8'd0);
				repeat ($urandom_range(1, 4)) send_byte(clean(8'($urandom)));
			end else begin
				send_byte(cfg_sync);
			end
			if (q.size() != 0) begin
				send_body(q);
				count += q.size() + 2;
			end
		end
	endtask

	task automatic test_register_settings(input logic [7:0] sync_value,
			input logic [15:0] scale, input int n_bytes);
		wait_drained();
		write_reg(REG_SYNC_CODE, {8'h00, sync_value});
		write_reg(REG_PULSES, scale);
		test_random_traffic(n_bytes);
	endtask

	function automatic logic [7:0] pick_sync();
		logic [7:0] s;
		do s = 8'($urandom);
		while (s == TYPE_CONTROL || s == TYPE_PARAM || s == TYPE_MOTOR ||
			s == CMD_RUN || s == CMD_STOP || s == CMD_TX);
		return s;
	endfunction

	initial begin
		clear_receiver_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_control_frames();
		test_param_frames();
		test_motor_frames();
		test_framing_corners();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		test_random_traffic(300);
		test_register_settings(8'd0, 16'hFFFF, 250);
		test_register_settings(8'd255, 16'h0000, 250);
		test_register_settings(pick_sync(), 16'($urandom), 250);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		test_register_settings(SYNC_CODE_RST, 16'($urandom), 200);
		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
design/fcr_pkg.sv
design/fcr_ifs.sv
design/fcr_framer.sv
design/fcr_exec.sv
design/framed_command_receiver.sv
verif/testbench.sv
